@@ rtl/tclq_pkg.sv @@
// shared types and codes for the two-class load queue
`default_nettype none
package tclq_pkg;
  localparam int OpW = 2;
  localparam int StatusW = 2;
  localparam int EntryFieldW = 7;

  typedef enum logic [OpW-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_SET_VIS = 2'd1,
    OP_PEEK    = 2'd2,
    OP_DONE    = 2'd3
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_WRONG = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_DEC   = 6'b001000,
    S_FIX   = 6'b010000,
    S_APP   = 6'b100000
  } state_t;
endpackage
`default_nettype wire

@@ rtl/tclq_ram.sv @@
// generic single-port ram with registered read
`default_nettype none
module tclq_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ rtl/two_class_load_queue.sv @@
// two-class load queue: foreground and background linked lists in link rams
// steps: peek, marks-only and rejected items take a read and a decode; enqueue adds
// an append step, complete an unlink step, and a move between queues both: one read, then one step per link write
// throughput: one item at a time; the next item can be taken in the result cycle
// reset: queue ends set to null, then a clearing pass over all ENTRIES entries, busy high
// results cannot be stalled: out_valid is high for exactly one cycle
`default_nettype none
module two_class_load_queue #(
  parameter int ENTRIES = 128
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        in_opcode,
  input  wire logic [6:0]                        in_entry,
  input  wire logic                              in_make_visible,
  output logic                                   out_valid,
  output logic [1:0]                             out_status,
  output logic [6:0]                             out_chosen_entry,
  output logic                                   out_chosen_is_visible,
  output logic                                   out_visible_queue_empty,
  output logic                                   out_background_queue_empty
);
  import tclq_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LW = $clog2(ENTRIES + 1);
  localparam int MW = LW + 2;
  localparam logic [LW-1:0] NullLink = LW'(ENTRIES);

  state_t state_r, state_nxt;
  op_t op_r;
  logic [AW-1:0] e_r;
  logic [6:0] e7_r;
  logic vis_r;
  logic [LW-1:0] fgh_r, fgt_r, bgh_r, bgt_r;
  logic [LW-1:0] p_r, n_r;
  logic cls_r;
  logic app_cls_r;
  logic do_app_r;
  logic [AW-1:0] clr_cnt_r;

  // next link ram, and meta ram holding {queued, visible, prev link}
  logic nx_we, mt_we;
  logic [AW-1:0] nx_addr, mt_addr;
  logic [LW-1:0] nx_wd, nx_rd;
  logic [MW-1:0] mt_wd, mt_rd;

  tclq_ram #(.Width(LW), .Depth(ENTRIES)) u_next (
    .clk(clk), .we(nx_we), .addr(nx_addr), .wdata(nx_wd), .rdata(nx_rd));
  tclq_ram #(.Width(MW), .Depth(ENTRIES)) u_meta (
    .clk(clk), .we(mt_we), .addr(mt_addr), .wdata(mt_wd), .rdata(mt_rd));

  logic ent_valid;
  assign ent_valid = ({{(32-EntryFieldW){1'b0}}, e7_r} < 32'(ENTRIES));

  // fields of the entry read back from the meta ram
  logic cur_vis, cur_q;
  logic [LW-1:0] rd_prev;
  assign cur_q   = mt_rd[LW+1];
  assign cur_vis = mt_rd[LW];
  assign rd_prev = mt_rd[LW-1:0];

  logic [LW-1:0] app_tail;
  assign app_tail = app_cls_r ? fgt_r : bgt_r;

  // result register
  logic out_valid_nxt;
  logic [1:0] st_nxt;
  logic [6:0] ch_nxt;
  logic chv_nxt;

  always_comb begin
    state_nxt = state_r;
    nx_we = 1'b0; mt_we = 1'b0;
    nx_addr = e_r; mt_addr = e_r;
    nx_wd = NullLink; mt_wd = '0;
    out_valid_nxt = 1'b0;
    st_nxt = ST_OK; ch_nxt = '0; chv_nxt = 1'b0;
    case (state_r)
      // clear marks of every entry after reset
      S_CLEAR: begin
        mt_addr = clr_cnt_r; mt_wd = {1'b0, 1'b0, NullLink}; mt_we = 1'b1;
        if (clr_cnt_r == AW'(ENTRIES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = S_READ;
      end
      // ram read of the entry is in flight
      S_READ: state_nxt = S_DEC;
      S_DEC: begin
        state_nxt = S_IDLE;
        out_valid_nxt = 1'b1;
        case (op_r)
          OP_ENQUEUE: begin
            if (!ent_valid || cur_q) st_nxt = ST_WRONG;
            else begin
              nx_we = 1'b1;
              state_nxt = S_APP;
            end
          end
          OP_SET_VIS: begin
            if (!ent_valid) st_nxt = ST_WRONG;
            else if (cur_vis != vis_r) begin
              if (cur_q) begin
                nx_we = 1'b1;
                state_nxt = S_FIX;
              end else begin
                mt_wd = {1'b0, vis_r, rd_prev}; mt_we = 1'b1;
              end
            end
          end
          OP_PEEK: begin
            if (fgh_r != NullLink) begin
              ch_nxt = 7'(fgh_r); chv_nxt = 1'b1;
            end else if (bgh_r != NullLink) ch_nxt = 7'(bgh_r);
            else st_nxt = ST_EMPTY;
          end
          default: begin
            if (!ent_valid || !cur_q) st_nxt = ST_WRONG;
            else begin
              mt_wd = {1'b0, cur_vis, NullLink}; mt_we = 1'b1;
              state_nxt = S_FIX;
            end
          end
        endcase
        if (state_nxt != S_IDLE) out_valid_nxt = 1'b0;
      end
      // unlink: prev's next becomes n, next's prev becomes p
      S_FIX: begin
        nx_addr = AW'(p_r); nx_wd = n_r; nx_we = (p_r != NullLink);
        mt_addr = AW'(n_r); mt_wd = {1'b1, cls_r, p_r}; mt_we = (n_r != NullLink);
        if (do_app_r) state_nxt = S_APP;
        else begin
          state_nxt = S_IDLE; out_valid_nxt = 1'b1;
        end
      end
      // append: entry meta and old tail's next
      S_APP: begin
        mt_addr = e_r; mt_wd = {1'b1, app_cls_r, app_tail}; mt_we = 1'b1;
        nx_addr = AW'(app_tail); nx_wd = LW'(e_r); nx_we = (app_tail != NullLink);
        state_nxt = S_IDLE; out_valid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_cnt_r <= '0;
      fgh_r <= NullLink; fgt_r <= NullLink; bgh_r <= NullLink; bgt_r <= NullLink;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= out_valid_nxt;
      if (out_valid_nxt) begin
        out_status <= st_nxt; out_chosen_entry <= ch_nxt;
        out_chosen_is_visible <= chv_nxt;
      end
      case (state_r)
        S_CLEAR: clr_cnt_r <= clr_cnt_r + AW'(1);
        S_IDLE: if (start) begin
          op_r <= op_t'(in_opcode); e7_r <= in_entry; e_r <= AW'(in_entry);
          vis_r <= in_make_visible;
        end
        S_DEC: begin
          p_r <= rd_prev; n_r <= nx_rd; cls_r <= cur_vis;
          app_cls_r <= (op_r == OP_SET_VIS) ? vis_r : 1'b0;
          do_app_r <= (op_r == OP_SET_VIS);
        end
        // queue ends of the class the entry leaves
        S_FIX: begin
          if (cls_r) begin
            if (p_r == NullLink) fgh_r <= n_r;
            if (n_r == NullLink) fgt_r <= p_r;
          end else begin
            if (p_r == NullLink) bgh_r <= n_r;
            if (n_r == NullLink) bgt_r <= p_r;
          end
        end
        S_APP: begin
          if (app_cls_r) begin
            if (fgt_r == NullLink) fgh_r <= LW'(e_r);
            fgt_r <= LW'(e_r);
          end else begin
            if (bgt_r == NullLink) bgh_r <= LW'(e_r);
            bgt_r <= LW'(e_r);
          end
        end
        default: ;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_visible_queue_empty    = (fgh_r == NullLink);
  assign out_background_queue_empty = (bgh_r == NullLink);

`ifndef SYNTH
  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) != S_IDLE) else $error("result with no item");
  a_heads_tails: assert property (@(posedge clk) disable iff (!rst_n)
    (fgh_r == NullLink) == (fgt_r == NullLink)) else $error("fg ends disagree");
  a_bg_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (bgh_r == NullLink) == (bgt_r == NullLink)) else $error("bg ends disagree");
`endif
endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// testbench for the two-class load queue: directed and random requests against a predictor
`timescale 1ns / 1ps
module tb_top;
  import tclq_pkg::*;

  localparam int NumEntries = 128;
  localparam int NullLink = NumEntries;
  localparam int RandomItems = 1650;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] chosen_entry;
    logic       chosen_is_visible;
    logic       fg_empty;
    logic       bg_empty;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_opcode = '0;
  logic [6:0] in_entry = '0;
  logic in_make_visible = 1'b0;
  logic out_valid;
  logic [1:0] out_status;
  logic [6:0] out_chosen_entry;
  logic out_chosen_is_visible;
  logic out_visible_queue_empty;
  logic out_background_queue_empty;

  // predictor state
  int unsigned fwd_link [NumEntries];
  int unsigned back_link [NumEntries];
  bit fg_mark [NumEntries];
  bit in_queue [NumEntries];
  int unsigned fg_head, fg_tail, bg_head, bg_tail;

  answer_t expected_answers [$];
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned answers_seen = 0;
  int unsigned peeks_hit = 0;
  int unsigned moves_seen = 0;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  two_class_load_queue #(.ENTRIES(NumEntries)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_entry(in_entry), .in_make_visible(in_make_visible),
    .out_valid(out_valid), .out_status(out_status), .out_chosen_entry(out_chosen_entry),
    .out_chosen_is_visible(out_chosen_is_visible),
    .out_visible_queue_empty(out_visible_queue_empty),
    .out_background_queue_empty(out_background_queue_empty)
  );

  // remove an entry from whichever list it sits in
  task automatic unlink_from_list(input int unsigned e, input bit fg);
    int unsigned p, n;
    p = back_link[e];
    n = fwd_link[e];
    if (p < NullLink) fwd_link[p] = n;
    else if (fg) fg_head = n;
    else bg_head = n;
    if (n < NullLink) back_link[n] = p;
    else if (fg) fg_tail = p;
    else bg_tail = p;
    fwd_link[e] = NullLink;
    back_link[e] = NullLink;
  endtask

  // join an entry to the tail of a list
  task automatic join_tail(input int unsigned e, input bit fg);
    int unsigned t;
    t = fg ? fg_tail : bg_tail;
    fwd_link[e] = NullLink;
    back_link[e] = t;
    if (t < NullLink) fwd_link[t] = e;
    else if (fg) fg_head = e;
    else bg_head = e;
    if (fg) fg_tail = e;
    else bg_tail = e;
  endtask

  function automatic void clear_queue_model();
    for (int i = 0; i < NumEntries; i++) begin
      fwd_link[i] = NullLink;
      back_link[i] = NullLink;
      fg_mark[i] = 1'b0;
      in_queue[i] = 1'b0;
    end
    fg_head = NullLink; fg_tail = NullLink;
    bg_head = NullLink; bg_tail = NullLink;
  endfunction

  // work out the answer to one request and update the queues
  task automatic predict_request(input op_t op, input int unsigned e, input bit vis);
    answer_t a;
    a = '0;
    a.status = ST_OK;
    case (op)
      OP_ENQUEUE: begin
        if (in_queue[e]) a.status = ST_WRONG;
        else begin
          fg_mark[e] = 1'b0;
          in_queue[e] = 1'b1;
          join_tail(e, 1'b0);
        end
      end
      OP_SET_VIS: begin
        if (fg_mark[e] != vis) begin
          if (in_queue[e]) begin
            unlink_from_list(e, fg_mark[e]);
            join_tail(e, vis);
            moves_seen++;
          end
          fg_mark[e] = vis;
        end
      end
      OP_PEEK: begin
        if (fg_head < NullLink) begin
          a.chosen_entry = fg_head[6:0];
          a.chosen_is_visible = 1'b1;
          peeks_hit++;
        end else if (bg_head < NullLink) begin
          a.chosen_entry = bg_head[6:0];
          peeks_hit++;
        end else a.status = ST_EMPTY;
      end
      default: begin
        if (!in_queue[e]) a.status = ST_WRONG;
        else begin
          unlink_from_list(e, fg_mark[e]);
          in_queue[e] = 1'b0;
        end
      end
    endcase
    a.fg_empty = (fg_head >= NullLink);
    a.bg_empty = (bg_head >= NullLink);
    expected_answers.push_back(a);
  endtask

  // send one item after a random gap; start stays high when no gap follows
  task automatic send_item(input op_t op, input int unsigned e, input bit vis);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      start <= 1'b0;
      in_entry <= 7'($urandom_range(0, 127));
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_entry <= e[6:0];
    in_make_visible <= vis;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(op, e, vis);
    items_sent++;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // check each result against the oldest expectation
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid) begin
      answers_seen++;
      if (expected_answers.size() == 0) report_mismatch("unexpected result", 1, 0);
      else begin
        want = expected_answers.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_chosen_entry !== want.chosen_entry)
          report_mismatch("chosen_entry", out_chosen_entry, want.chosen_entry);
        if (out_chosen_is_visible !== want.chosen_is_visible)
          report_mismatch("chosen_is_visible", out_chosen_is_visible, want.chosen_is_visible);
        if (out_visible_queue_empty !== want.fg_empty)
          report_mismatch("visible_queue_empty", out_visible_queue_empty, want.fg_empty);
        if (out_background_queue_empty !== want.bg_empty)
          report_mismatch("background_queue_empty", out_background_queue_empty, want.bg_empty);
      end
    end
  end

  // stop sending and wait until every expected result has come
  task automatic wait_for_answers();
    start <= 1'b0;
    @(posedge clk);
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  // empty queues, extremes of handle, wrong-state cases
  task automatic test_directed();
    send_item(OP_PEEK, 127, 1'b1);
    send_item(OP_DONE, 0, 1'b0);
    send_item(OP_SET_VIS, 127, 1'b1);
    send_item(OP_SET_VIS, 127, 1'b1);
    send_item(OP_ENQUEUE, 127, 1'b0);
    send_item(OP_ENQUEUE, 0, 1'b0);
    send_item(OP_ENQUEUE, 0, 1'b1);
    send_item(OP_ENQUEUE, 85, 1'b0);
    send_item(OP_PEEK, 0, 1'b0);
    send_item(OP_SET_VIS, 0, 1'b1);
    send_item(OP_PEEK, 0, 1'b0);
    send_item(OP_SET_VIS, 85, 1'b1);
    send_item(OP_SET_VIS, 0, 1'b1);
    send_item(OP_DONE, 85, 1'b0);
    send_item(OP_SET_VIS, 0, 1'b0);
    send_item(OP_DONE, 0, 1'b0);
    send_item(OP_DONE, 0, 1'b0);
    send_item(OP_ENQUEUE, 0, 1'b0);
    send_item(OP_DONE, 127, 1'b0);
    send_item(OP_DONE, 0, 1'b0);
    send_item(OP_PEEK, 42, 1'b0);
    send_item(OP_SET_VIS, 85, 1'b0);
  endtask

  // random traffic, mostly over a small pool of entries so that queues stay populated
  task automatic test_random_traffic(input int unsigned n);
    int unsigned roll, e, pool;
    op_t op;
    for (int i = 0; i < n; i++) begin
      pool = (i % 400 < 300) ? 15 : 127;
      roll = $urandom_range(0, 99);
      if (roll < 35) op = OP_ENQUEUE;
      else if (roll < 60) op = OP_SET_VIS;
      else if (roll < 80) op = OP_PEEK;
      else op = OP_DONE;
      e = $urandom_range(0, pool);
      send_item(op, e, 1'($urandom_range(0, 1)));
      if (i == n / 2) wait_for_answers();
    end
  endtask

  initial begin
    clear_queue_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_for_answers();
    test_random_traffic(RandomItems);
    wait_for_answers();
    repeat (20) @(posedge clk);
    $display("sent %0d items, checked %0d results", items_sent, answers_seen);
    $display("peeks with an entry: %0d, moves between queues: %0d", peeks_hit, moves_seen);
    if (fail_count == 0 && expected_answers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #200000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
